// File: hw/rtl/piv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piv_pkg
// shared types, constants and the byte-wide crc32 update
// ----------------------------------------------------------------------------
package piv_pkg;

    localparam int RULE_BYTES = 4;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    localparam logic [1:0] CFG_MAGIC   = 2'd0;
    localparam logic [1:0] CFG_VERSION = 2'd1;
    localparam logic [1:0] CFG_DOMAIN  = 2'd2;
    localparam logic [1:0] CFG_MAX     = 2'd3;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_IO       = 3'd1,
        ST_MAGIC    = 3'd2,
        ST_VERSION  = 3'd3,
        ST_DOMAIN   = 3'd4,
        ST_TOO_MANY = 3'd5,
        ST_CRC      = 3'd6
    } status_t;

    // one classified request from front to back
    typedef struct packed {
        logic [7:0]  data;
        logic        rule_valid;
        logic [9:0]  address;
        logic        verdict;
        status_t     status;
        logic [7:0]  count;
    } result_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/piv_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piv_front
// parses the framed stream, runs the crc and classifies each byte
// ----------------------------------------------------------------------------
module piv_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    input  logic [31:0]       magic_word,
    input  logic [7:0]        expected_version,
    input  logic [7:0]        required_domain,
    input  logic [7:0]        max_rules,
    output piv_pkg::result_t  res
);
    import piv_pkg::*;

    typedef enum logic [1:0] { PH_HEADER, PH_RULES, PH_CRC, PH_DONE } phase_t;

    phase_t       phase_reg, phase_next;
    logic [9:0]   offset_reg, offset_next;
    logic [55:0]  hdr_reg, hdr_next;
    logic [31:0]  crc_reg, crc_next, crc_upd;
    logic [23:0]  rxcrc_reg, rxcrc_next;
    logic [15:0]  count_reg, count_next;
    logic [17:0]  rule_total;
    logic [15:0]  dcount;

    assign crc_upd    = crc_byte(crc_reg, in_byte);
    assign rule_total = {2'd0, count_reg} * 18'(RULE_BYTES);
    assign dcount     = {in_byte, hdr_reg[55:48]};

    always_comb
    begin
        phase_next = phase_reg;
        offset_next = offset_reg;
        hdr_next = hdr_reg;
        crc_next = crc_reg;
        rxcrc_next = rxcrc_reg;
        count_next = count_reg;
        res = '0;
        res.status = ST_OK;
        unique case (phase_reg)
            PH_HEADER:
            begin
                crc_next = crc_upd;
                if (offset_reg[2:0] != 3'd7)
                begin
                    hdr_next[offset_reg[2:0]*8 +: 8] = in_byte;
                    offset_next = offset_reg + 10'd1;
                    if (in_last)
                    begin
                        res.verdict = 1'b1;
                        res.status = ST_IO;
                    end
                end
                else
                begin
                    offset_next = '0;
                    count_next = dcount;
                    res.verdict = 1'b1;
                    if (hdr_reg[31:0] != magic_word)            res.status = ST_MAGIC;
                    else if (hdr_reg[39:32] != expected_version) res.status = ST_VERSION;
                    else if (hdr_reg[47:40] != required_domain)  res.status = ST_DOMAIN;
                    else if (dcount > {8'd0, max_rules})         res.status = ST_TOO_MANY;
                    else if (in_last)                            res.status = ST_IO;
                    else
                    begin
                        res.verdict = 1'b0;
                        phase_next = (dcount == 16'd0) ? PH_CRC : PH_RULES;
                    end
                    if (res.verdict)
                        phase_next = PH_DONE;
                end
            end
            PH_RULES:
            begin
                res.rule_valid = 1'b1;
                res.data = in_byte;
                res.address = offset_reg;
                crc_next = crc_upd;
                offset_next = offset_reg + 10'd1;
                if (in_last)
                begin
                    res.verdict = 1'b1;
                    res.status = ST_IO;
                    phase_next = PH_DONE;
                end
                else if ({8'd0, offset_next} >= rule_total)
                begin
                    offset_next = '0;
                    phase_next = PH_CRC;
                end
            end
            PH_CRC:
            begin
                if (offset_reg[1:0] != 2'd3)
                begin
                    rxcrc_next[offset_reg[1:0]*8 +: 8] = in_byte;
                    offset_next = offset_reg + 10'd1;
                    if (in_last)
                    begin
                        res.verdict = 1'b1;
                        res.status = ST_IO;
                        phase_next = PH_DONE;
                    end
                end
                else
                begin
                    offset_next = '0;
                    res.verdict = 1'b1;
                    phase_next = PH_DONE;
                    if ({in_byte, rxcrc_reg} == ~crc_reg)
                    begin
                        res.status = ST_OK;
                        res.count = count_reg[7:0];
                    end
                    else
                        res.status = ST_CRC;
                end
            end
            default: ;
        endcase
        if (in_last)
        begin
            phase_next = PH_HEADER;
            offset_next = '0;
            hdr_next = '0;
            crc_next = CRC_INIT;
            rxcrc_next = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            offset_reg <= '0;
            hdr_reg    <= '0;
            crc_reg    <= CRC_INIT;
            rxcrc_reg  <= '0;
            count_reg  <= '0;
        end
        else if (in_fire)
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            hdr_reg    <= hdr_next;
            crc_reg    <= crc_next;
            rxcrc_reg  <= rxcrc_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        res.rule_valid |-> phase_reg == PH_RULES) else $error("rule byte outside rules");
    assert property (@(posedge clk) disable iff (!rst_n)
        (res.count != 8'd0) |-> (res.verdict && res.status == ST_OK))
        else $error("count without ok verdict");
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_last) |=> (phase_reg == PH_HEADER && offset_reg == '0))
        else $error("no restart after last byte");

endmodule

// File: hw/rtl/piv_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piv_queue
// two-entry fifo between front and back
// ----------------------------------------------------------------------------
module piv_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  piv_pkg::result_t  push_data,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output piv_pkg::result_t  head
);
    import piv_pkg::*;

    result_t     mem_reg [2];
    logic        wr_reg, rd_reg;
    logic [1:0]  cnt_reg;

    assign full      = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign head      = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full)) else $error("queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !not_empty)) else $error("queue underflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count out of range");

endmodule

// File: hw/rtl/piv_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piv_back
// output register that presents each result to the downstream side
// ----------------------------------------------------------------------------
module piv_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_not_empty,
    input  piv_pkg::result_t  q_head,
    output logic              q_pop,
    input  logic              out_stall,
    output logic              out_valid,
    output piv_pkg::result_t  out_data
);
    import piv_pkg::*;

    logic     valid_reg;
    result_t  data_reg;
    logic     load;

    assign load      = q_not_empty && (!valid_reg || !out_stall);
    assign q_pop     = load;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= q_head;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && out_stall) |=> (valid_reg && $stable(data_reg)))
        else $error("stalled result changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        (load) |=> valid_reg) else $error("load lost");
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_stall && !q_not_empty) |=> !valid_reg)
        else $error("result repeated");

endmodule

// File: hw/rtl/policy_image_validator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// policy_image_validator
// framed policy file checker with crc32 and rule byte output
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle while the two-entry queue has room, and
// each byte gives exactly one result. The parse and the byte-wide crc32
// update both settle within the accepting cycle; the result is written into
// the queue and then loaded from it into the output register. Results pass
// the queue and the output register, so a stalled output does not hold the
// input until the queue fills.
module policy_image_validator
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // input requests
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  stream_byte,
    input  logic        last_byte,
    // result requests
    output logic        out_valid,
    input  logic        out_stall,
    output logic        rule_byte_valid,
    output logic [7:0]  rule_byte,
    output logic [9:0]  rule_address,
    output logic        verdict_valid,
    output logic [2:0]  status,
    output logic [7:0]  loaded_rules
);
    import piv_pkg::*;

    logic [31:0] magic_reg;
    logic [7:0]  version_reg, domain_reg, max_reg;
    logic        in_fire, q_full, q_not_empty, q_pop;
    result_t     fr_res, q_head, out_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg   <= '0;
            version_reg <= '0;
            domain_reg  <= '0;
            max_reg     <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MAGIC:   magic_reg   <= cfg_data;
                CFG_VERSION: version_reg <= cfg_data[7:0];
                CFG_DOMAIN:  domain_reg  <= cfg_data[7:0];
                CFG_MAX:     max_reg     <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // accept while the queue has room
    assign in_stall = q_full;
    assign in_fire  = in_valid && !q_full;

    piv_front u_front
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_fire          (in_fire),
        .in_byte          (stream_byte),
        .in_last          (last_byte),
        .magic_word       (magic_reg),
        .expected_version (version_reg),
        .required_domain  (domain_reg),
        .max_rules        (max_reg),
        .res              (fr_res)
    );

    piv_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_fire),
        .push_data (fr_res),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    piv_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_data    (out_data)
    );

    assign rule_byte_valid = out_data.rule_valid;
    assign rule_byte       = out_data.data;
    assign rule_address    = out_data.address;
    assign verdict_valid   = out_data.verdict;
    assign status          = out_data.status;
    assign loaded_rules    = out_data.count;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// policy_image_validator testbench
// feeds framed policy files byte by byte under random idling and stalls,
// predicts each result from an internal model of the parser and crc32, and
// compares every result field by field in order
// ----------------------------------------------------------------------------

class file_check_board;
    // configuration copy
    logic [31:0] magic;
    logic [7:0]  version;
    logic [7:0]  domain;
    logic [7:0]  capacity;
    // parser state copy
    logic [1:0]  stage;
    logic [9:0]  offset;
    logic [63:0] header;
    logic [31:0] running_crc;
    logic [31:0] trailer_crc;
    logic [15:0] declared;
    piv_pkg::result_t pending[$];
    int errors;

    localparam logic [1:0] S_HEADER = 2'd0;
    localparam logic [1:0] S_RULES  = 2'd1;
    localparam logic [1:0] S_CRC    = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    function new();
        magic = '0; version = '0; domain = '0; capacity = '0;
        errors = 0;
        restart();
    endfunction

    function void restart();
        stage = S_HEADER; offset = '0; header = '0;
        running_crc = 32'hFFFF_FFFF; trailer_crc = '0; declared = '0;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] value);
        case (idx)
            piv_pkg::CFG_MAGIC:   magic = value;
            piv_pkg::CFG_VERSION: version = value[7:0];
            piv_pkg::CFG_DOMAIN:  domain = value[7:0];
            default:              capacity = value[7:0];
        endcase
    endfunction

    function logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
        end
        return c;
    endfunction

    // note an accepted request and queue the result it must produce
    function void note_byte(logic [7:0] b, logic last);
        piv_pkg::result_t r;
        r = '0;
        r.status = piv_pkg::ST_OK;
        case (stage)
            S_HEADER:
            begin
                header = header | ({56'd0, b} << (8 * offset[2:0]));
                running_crc = crc_step(running_crc, b);
                if (offset < 7)
                begin
                    offset++;
                    if (last)
                    begin
                        r.verdict = 1'b1; r.status = piv_pkg::ST_IO;
                    end
                end
                else
                begin
                    offset = '0;
                    declared = header[63:48];
                    r.verdict = 1'b1;
                    if (header[31:0] != magic) r.status = piv_pkg::ST_MAGIC;
                    else if (header[39:32] != version) r.status = piv_pkg::ST_VERSION;
                    else if (header[47:40] != domain) r.status = piv_pkg::ST_DOMAIN;
                    else if (declared > {8'd0, capacity}) r.status = piv_pkg::ST_TOO_MANY;
                    else if (last) r.status = piv_pkg::ST_IO;
                    else
                    begin
                        r.verdict = 1'b0;
                        stage = (declared == 0) ? S_CRC : S_RULES;
                    end
                    if (r.verdict) stage = S_DONE;
                end
            end
            S_RULES:
            begin
                r.rule_valid = 1'b1;
                r.data = b;
                r.address = offset;
                running_crc = crc_step(running_crc, b);
                offset = offset + 10'd1;
                if (last)
                begin
                    r.verdict = 1'b1; r.status = piv_pkg::ST_IO; stage = S_DONE;
                end
                else if (32'(offset) >= 32'(declared) * piv_pkg::RULE_BYTES)
                begin
                    offset = '0; stage = S_CRC;
                end
            end
            S_CRC:
            begin
                trailer_crc = trailer_crc | ({24'd0, b} << (8 * offset[1:0]));
                if (offset < 3)
                begin
                    offset++;
                    if (last)
                    begin
                        r.verdict = 1'b1; r.status = piv_pkg::ST_IO; stage = S_DONE;
                    end
                end
                else
                begin
                    offset = '0;
                    r.verdict = 1'b1;
                    stage = S_DONE;
                    if (trailer_crc == ~running_crc) r.count = declared[7:0];
                    else r.status = piv_pkg::ST_CRC;
                end
            end
            default: ;
        endcase
        if (last) restart();
        pending.push_back(r);
    endfunction

    function void report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endfunction

    function void check_result(piv_pkg::result_t got);
        piv_pkg::result_t want;
        if (pending.size() == 0)
        begin
            $display("mismatch: result with no request waiting");
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.rule_valid != want.rule_valid) report("rule_byte_valid", got.rule_valid, want.rule_valid);
        if (got.data != want.data) report("rule_byte", got.data, want.data);
        if (got.address != want.address) report("rule_address", got.address, want.address);
        if (got.verdict != want.verdict) report("verdict_valid", got.verdict, want.verdict);
        if (got.status != want.status) report("status", got.status, want.status);
        if (got.count != want.count) report("loaded_rules", got.count, want.count);
    endfunction
endclass

module testbench;
    import piv_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  stream_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall;
    logic        rule_byte_valid;
    logic [7:0]  rule_byte;
    logic [9:0]  rule_address;
    logic        verdict_valid;
    logic [2:0]  status;
    logic [7:0]  loaded_rules;

    file_check_board board;
    int  idle_pct;      // sender idle chance in percent
    int  stall_pct;     // receiver stall chance in percent
    int  bytes_sent;
    longint cycles;
    logic [7:0] file_bytes[$];

    policy_image_validator u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run guard: generous against the slowest legal run
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 400000)
            begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    // result side: sample at rising edge, new stall at falling edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            result_t r;
            r.data = rule_byte;
            r.rule_valid = rule_byte_valid;
            r.address = rule_address;
            r.verdict = verdict_valid;
            r.status = status_t'(status);
            r.count = loaded_rules;
            board.check_result(r);
        end
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic write_register(logic [1:0] idx, logic [31:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        board.set_register(idx, value);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // one request, waiting for acceptance; valid stays high between back to back bytes
    task automatic send_byte(logic [7:0] b, logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        stream_byte <= b;
        last_byte   <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_byte(b, last);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (board.pending.size() != 0) @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    // build a file; fault picks a broken field, 0 gives a good file
    task automatic build_file(int rules, int fault, int tail, int cut);
        logic [31:0] crc;
        logic [7:0]  b;
        file_bytes.delete();
        for (int i = 0; i < 4; i++) file_bytes.push_back(board.magic[8*i +: 8]);
        file_bytes.push_back(board.version);
        file_bytes.push_back(board.domain);
        file_bytes.push_back(rules[7:0]);
        file_bytes.push_back(rules[15:8]);
        case (fault)
            1: file_bytes[$urandom_range(3)] ^= 8'(1 << $urandom_range(7));
            2: file_bytes[4] ^= 8'($urandom_range(255, 1));
            3: file_bytes[5] ^= 8'($urandom_range(255, 1));
            default: ;
        endcase
        for (int i = 0; i < rules * RULE_BYTES; i++) file_bytes.push_back(8'($urandom));
        crc = 32'hFFFF_FFFF;
        foreach (file_bytes[i]) crc = board.crc_step(crc, file_bytes[i]);
        crc = ~crc;
        if (fault == 4) crc ^= 32'(1) << $urandom_range(31);
        for (int i = 0; i < 4; i++) file_bytes.push_back(crc[8*i +: 8]);
        for (int i = 0; i < tail; i++) file_bytes.push_back(8'($urandom));
        if (cut > 0 && cut < file_bytes.size())
            while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    endtask

    task automatic run_phase(int n_bytes);
        int stop;
        int kind;
        stop = bytes_sent + n_bytes;
        while (bytes_sent < stop)
        begin
            kind = $urandom_range(99);
            if (kind < 60)
                build_file($urandom_range(board.capacity < 6 ? board.capacity : 6), 0,
                           ($urandom_range(3) == 0) ? $urandom_range(3) : 0, 0);
            else if (kind < 80)
                build_file($urandom_range(3), $urandom_range(4, 1), $urandom_range(2), 0);
            else if (kind < 88)
                // rejected at the header, so the rule section is cut short
                build_file(board.capacity + 1 + $urandom_range(2), 0, 0,
                           $urandom_range(16, 9));
            else if (kind < 95)
                build_file($urandom_range(4), 0, 0, $urandom_range(20, 1));
            else
            begin
                // pure noise up to a last flag
                file_bytes.delete();
                repeat ($urandom_range(12, 1)) file_bytes.push_back(8'($urandom));
            end
            send_file();
        end
    endtask

    task automatic set_all(logic [31:0] m, logic [7:0] v, logic [7:0] d, logic [7:0] c);
        write_register(CFG_MAGIC, m);
        write_register(CFG_VERSION, v);
        write_register(CFG_DOMAIN, d);
        write_register(CFG_MAX, c);
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        cfg_write = 1'b0; cfg_index = '0; cfg_data = '0;
        in_valid = 1'b0; stream_byte = '0; last_byte = 1'b0;
        out_stall = 1'b0;
        idle_pct = 0; stall_pct = 0; bytes_sent = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset configuration, zero magic, zero rules
        build_file(0, 0, 0, 0);
        send_file();
        // early end on the very first byte
        build_file(0, 0, 0, 1);
        send_file();
        drain();

        // extremes of all registers
        set_all(32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF);
        build_file(1, 0, 2, 0);
        send_file();
        build_file(256, 0, 0, 12);    // count above capacity, high count byte set
        send_file();
        build_file(1, 1, 0, 0);       // bad magic
        send_file();
        build_file(1, 2, 0, 0);       // bad version
        send_file();
        build_file(1, 3, 0, 0);       // bad domain
        send_file();
        build_file(1, 4, 0, 0);       // crc fail
        send_file();
        build_file(0, 0, 0, 8);       // last flag on eighth header byte
        send_file();
        build_file(2, 0, 0, 11);      // ends inside the rules
        send_file();
        build_file(0, 0, 0, 10);      // ends inside the crc
        send_file();
        drain();

        set_all(32'h1234_ABCD, 8'h00, 8'h5A, 8'h00);
        build_file(0, 0, 0, 0);
        send_file();
        build_file(1, 0, 0, 0);       // capacity zero rejects any rule
        send_file();
        drain();

        // random phases with different idling and stall chances, each under its own settings
        for (int p = 0; p < 4; p++)
        begin
            set_all($urandom, (p == 1) ? 8'h00 : 8'($urandom), 8'($urandom),
                    (p == 2) ? 8'hFF : 8'($urandom_range(12, 1)));
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 69; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 69; end
                default: begin idle_pct = 7; stall_pct = 7; end
            endcase
            run_phase(85);
            // sender holds off until every result is back
            drain();
        end

        idle_pct = 0;
        stall_pct = 0;
        drain();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
